>>> src/assert_macros.svh
// Assertion macros shared by checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

>>> src/fcds_pkg.sv
// Package: shared constants and types for the DMA sequencer
package fcds_pkg;
    localparam int NUM_CHANNELS = 4;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_TRIG  = 2'd2,
        CMD_STEP  = 2'd3
    } t_cmd;

    localparam logic [3:0] REG_CTL_LO = 4'd10;
    localparam logic [3:0] REG_CTL_HI = 4'd11;

    localparam logic [1:0] T_IMM = 2'd0;
    localparam logic [1:0] T_VBL = 2'd1;
    localparam logic [1:0] T_HBL = 2'd2;
    localparam logic [1:0] T_SPC = 2'd3;

    localparam logic [2:0] OCC_VBL   = 3'd0;
    localparam logic [2:0] OCC_HBL   = 3'd1;
    localparam logic [2:0] OCC_VIDEO = 3'd2;
    localparam logic [2:0] OCC_FIFOA = 3'd3;
    localparam logic [2:0] OCC_FIFOB = 3'd4;

    localparam logic [27:0] FIFO_A_ADDR = 28'h40000A0;
    localparam logic [27:0] FIFO_B_ADDR = 28'h40000A4;

    typedef struct packed {
        logic [1:0] dst;
        logic [1:0] src;
        logic       rep;
        logic       size;
        logic       drq;
        logic [1:0] timing;
        logic       irq;
        logic       en;
    } t_ctl;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  chan;
        logic [3:0]  reg_index;
        logic [7:0]  data_byte;
        logic [2:0]  occasion;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic        xfer_valid;
        logic [1:0]  xfer_channel;
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic        word_size;
        logic        do_read;
        logic        sequential;
        logic        irq_request;
        logic        block_done;
        logic        busy_res;
    } t_result;

    function automatic logic [27:0] smask(input logic [1:0] c);
        return (c == 2'd0) ? 28'h7FFFFFF : 28'hFFFFFFF;
    endfunction
    function automatic logic [27:0] dmask(input logic [1:0] c);
        return (c == 2'd3) ? 28'hFFFFFFF : 28'h7FFFFFF;
    endfunction
    function automatic logic [16:0] cmask(input logic [1:0] c);
        return (c == 2'd3) ? 17'hFFFF : 17'h3FFF;
    endfunction
endpackage

>>> src/fcds_core.sv
// Channel state and the single-pass update for one item
module fcds_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  fcds_pkg::t_item    i_item,
    output fcds_pkg::t_result  o_res
);
    localparam int N = fcds_pkg::NUM_CHANNELS;

    logic [27:0]    r_src [4];
    logic [27:0]    r_dst [4];
    logic [16:0]    r_cnt [4];
    fcds_pkg::t_ctl r_ctl [4];
    logic [31:0]    r_wsrc [4];
    logic [31:0]    r_wdst [4];
    logic [16:0]    r_wcnt [4];
    logic [3:0]     r_pend, r_seq;

    logic [27:0]    n_src [4];
    logic [27:0]    n_dst [4];
    logic [16:0]    n_cnt [4];
    fcds_pkg::t_ctl n_ctl [4];
    logic [31:0]    n_wsrc [4];
    logic [31:0]    n_wdst [4];
    logic [16:0]    n_wcnt [4];
    logic [3:0]     n_pend, n_seq;

    always_comb begin
        logic [1:0]  c, when, dctl;
        logic [7:0]  d, pg;
        logic        found, fifo, word, was;
        logic [31:0] unit, al;
        logic [16:0] cnt, dec;
        logic [27:0] t28;
        logic [16:0] t17;
        n_src = r_src; n_dst = r_dst; n_cnt = r_cnt; n_ctl = r_ctl;
        n_wsrc = r_wsrc; n_wdst = r_wdst; n_wcnt = r_wcnt;
        n_pend = r_pend; n_seq = r_seq;
        o_res = '0;
        c = i_item.chan;
        d = i_item.data_byte;
        found = 1'b0; fifo = 1'b0; word = 1'b0; was = 1'b0;
        when = '0; dctl = '0; unit = '0; al = '0; cnt = '0; dec = '0;
        t28 = '0; t17 = '0; pg = '0;
        case (i_item.cmd)
            fcds_pkg::CMD_WRITE: if (32'(c) < N) begin
                if (i_item.reg_index < 4'd4) begin
                    t28 = r_src[c];
                    case (i_item.reg_index[1:0])
                        2'd0: t28[7:0] = d;
                        2'd1: t28[15:8] = d;
                        2'd2: t28[23:16] = d;
                        default: t28[27:24] = d[3:0];
                    endcase
                    n_src[c] = t28 & fcds_pkg::smask(c);
                end else if (i_item.reg_index < 4'd8) begin
                    t28 = r_dst[c];
                    case (i_item.reg_index[1:0])
                        2'd0: t28[7:0] = d;
                        2'd1: t28[15:8] = d;
                        2'd2: t28[23:16] = d;
                        default: t28[27:24] = d[3:0];
                    endcase
                    n_dst[c] = t28 & fcds_pkg::dmask(c);
                end else if (i_item.reg_index < 4'd10) begin
                    t17 = r_cnt[c];
                    if (i_item.reg_index[0]) t17[15:8] = d; else t17[7:0] = d;
                    t17 = t17 & fcds_pkg::cmask(c);
                    if (t17 == '0) t17 = fcds_pkg::cmask(c) + 17'd1;
                    n_cnt[c] = t17;
                end else if (i_item.reg_index == fcds_pkg::REG_CTL_LO) begin
                    n_ctl[c].dst = d[6:5];
                    n_ctl[c].src[0] = d[7];
                end else if (i_item.reg_index == fcds_pkg::REG_CTL_HI) begin
                    was = r_ctl[c].en;
                    when = d[5:4];
                    n_ctl[c].en = d[7];
                    n_ctl[c].irq = d[6];
                    n_ctl[c].timing = when;
                    n_ctl[c].drq = (c == 2'd3) ? d[3] : 1'b0;
                    n_ctl[c].size = d[2];
                    n_ctl[c].rep = (when != fcds_pkg::T_IMM) ? d[1] : 1'b0;
                    n_ctl[c].src[1] = d[0];
                    if (!d[7]) n_pend[c] = 1'b0;
                    else if (!was) begin
                        pg = {4'd0, r_src[c][27:24]};
                        if (pg >= 8'h08 && pg <= 8'h0D) n_ctl[c].src = 2'd0;
                        fifo = (when == fcds_pkg::T_SPC) && (c == 2'd1 || c == 2'd2);
                        if (fifo) begin
                            n_ctl[c].size = 1'b1;
                            cnt = 17'd4;
                        end else begin
                            cnt = r_cnt[c] & fcds_pkg::cmask(c);
                            if (cnt == '0) cnt = fcds_pkg::cmask(c) + 17'd1;
                        end
                        n_seq[c] = 1'b0;
                        al = n_ctl[c].size ? 32'd3 : 32'd1;
                        n_wcnt[c] = cnt;
                        n_wsrc[c] = {4'd0, r_src[c]} & ~al;
                        n_wdst[c] = {4'd0, r_dst[c]} & ~al;
                        if (when == fcds_pkg::T_IMM && n_ctl[c].src != 2'd3)
                            n_pend[c] = 1'b1;
                    end
                end
            end
            fcds_pkg::CMD_READ: if (32'(c) < N) begin
                if (i_item.reg_index == fcds_pkg::REG_CTL_LO)
                    o_res.read_byte = {r_ctl[c].src[0], r_ctl[c].dst, 5'd0};
                else if (i_item.reg_index == fcds_pkg::REG_CTL_HI)
                    o_res.read_byte = {r_ctl[c].en, r_ctl[c].irq, r_ctl[c].timing,
                                       r_ctl[c].drq, r_ctl[c].size, r_ctl[c].rep,
                                       r_ctl[c].src[1]};
            end
            fcds_pkg::CMD_TRIG: begin
                for (int k = 0; k < N; k++) begin
                    logic arm;
                    arm = 1'b0;
                    if (i_item.occasion == fcds_pkg::OCC_VBL)
                        arm = r_ctl[k].timing == fcds_pkg::T_VBL;
                    else if (i_item.occasion == fcds_pkg::OCC_HBL)
                        arm = r_ctl[k].timing == fcds_pkg::T_HBL;
                    else if (i_item.occasion == fcds_pkg::OCC_VIDEO)
                        arm = (k == 3) && r_ctl[k].timing == fcds_pkg::T_SPC;
                    else if (i_item.occasion == fcds_pkg::OCC_FIFOA)
                        arm = (k == 1 || k == 2) && r_dst[k] == fcds_pkg::FIFO_A_ADDR
                              && r_ctl[k].timing == fcds_pkg::T_SPC;
                    else if (i_item.occasion == fcds_pkg::OCC_FIFOB)
                        arm = (k == 1 || k == 2) && r_dst[k] == fcds_pkg::FIFO_B_ADDR
                              && r_ctl[k].timing == fcds_pkg::T_SPC;
                    if (arm && r_ctl[k].en && r_ctl[k].src != 2'd3) n_pend[k] = 1'b1;
                end
            end
            default: begin
                for (int k = N - 1; k >= 0; k--)
                    if (r_pend[k]) begin
                        found = 1'b1;
                        c = 2'(k);
                    end
                if (found) begin
                    fifo = (r_ctl[c].timing == fcds_pkg::T_SPC) && (c == 2'd1 || c == 2'd2);
                    word = fifo | r_ctl[c].size;
                    dctl = fifo ? 2'd2 : r_ctl[c].dst;
                    unit = word ? 32'd4 : 32'd2;
                    o_res.xfer_valid = 1'b1;
                    o_res.xfer_channel = c;
                    o_res.src_address = r_wsrc[c];
                    o_res.dst_address = r_wdst[c];
                    o_res.word_size = word;
                    o_res.do_read = r_wsrc[c] >= 32'h02000000;
                    o_res.sequential = r_seq[c];
                    case (r_ctl[c].src)
                        2'd1: n_wsrc[c] = r_wsrc[c] - unit;
                        2'd2: n_wsrc[c] = r_wsrc[c];
                        default: n_wsrc[c] = r_wsrc[c] + unit;
                    endcase
                    case (dctl)
                        2'd1: n_wdst[c] = r_wdst[c] - unit;
                        2'd2: n_wdst[c] = r_wdst[c];
                        default: n_wdst[c] = r_wdst[c] + unit;
                    endcase
                    dec = r_wcnt[c] - 17'd1;
                    n_wcnt[c] = dec;
                    n_seq[c] = 1'b1;
                    if (dec == '0) begin
                        n_pend[c] = 1'b0;
                        o_res.block_done = 1'b1;
                        o_res.irq_request = r_ctl[c].irq;
                        if (r_ctl[c].rep) begin
                            if (fifo) cnt = 17'd4;
                            else begin
                                cnt = r_cnt[c] & fcds_pkg::cmask(c);
                                if (cnt == '0) cnt = fcds_pkg::cmask(c) + 17'd1;
                            end
                            if (fifo) n_ctl[c].size = 1'b1;
                            n_seq[c] = 1'b0;
                            n_wcnt[c] = cnt;
                            al = n_ctl[c].size ? 32'd3 : 32'd1;
                            if (r_ctl[c].dst == 2'd3 && !fifo)
                                n_wdst[c] = {4'd0, r_dst[c]} & ~al;
                        end else n_ctl[c].en = 1'b0;
                    end
                end
            end
        endcase
        o_res.busy_res = n_pend != 4'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_src[k] <= '0; r_dst[k] <= '0; r_cnt[k] <= '0; r_ctl[k] <= '0;
                r_wsrc[k] <= '0; r_wdst[k] <= '0; r_wcnt[k] <= '0;
            end
            r_pend <= '0;
            r_seq <= '0;
        end else if (i_go) begin
            r_src <= n_src; r_dst <= n_dst; r_cnt <= n_cnt; r_ctl <= n_ctl;
            r_wsrc <= n_wsrc; r_wdst <= n_wdst; r_wcnt <= n_wcnt;
            r_pend <= n_pend; r_seq <= n_seq;
        end
    end
endmodule

>>> src/fcds_outreg.sv
// Result register with a skid slot on the output channel
module fcds_outreg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  fcds_pkg::t_result  i_res,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output fcds_pkg::t_result  o_res
);
    logic              r_v, r_sv;
    fcds_pkg::t_result r_d, r_sd;

    assign o_full  = r_sv;
    assign o_valid = r_v;
    assign o_res   = r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (!r_v || !i_stall) begin
                r_v <= r_sv | i_valid;
                r_d <= r_sv ? r_sd : i_res;
                r_sv <= r_sv && i_valid;
                if (r_sv && i_valid) r_sd <= i_res;
            end else if (i_valid) begin
                r_sv <= 1'b1;
                r_sd <= i_res;
            end
        end
    end
endmodule

>>> src/four_channel_dma_sequencer.sv
// Top level of the four-channel DMA sequencer
//  channel | signals                          | beat
//  in      | i_valid / o_stall, command..occ  | one command
//  out     | o_valid / i_stall, result fields | one result
// One beat a cycle while the input is not stalled: an item enters the input
// register, is decoded and applied to channel state in one pass, and its result
// is registered in the output stage. A two-entry output stage absorbs a stall;
// while both entries hold a result the item waits in the input register, and
// only then is the input stalled. Synchronous active-low reset clears all channel state.
module four_channel_dma_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [1:0]  i_chan,
    input  logic [3:0]  i_reg_index,
    input  logic [7:0]  i_data_byte,
    input  logic [2:0]  i_occasion,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_byte,
    output logic        o_xfer_valid,
    output logic [1:0]  o_xfer_channel,
    output logic [31:0] o_src_address,
    output logic [31:0] o_dst_address,
    output logic        o_word_size,
    output logic        o_do_read,
    output logic        o_sequential,
    output logic        o_irq_request,
    output logic        o_block_done,
    output logic        o_busy_res
);
    logic              r_iv;
    fcds_pkg::t_item   r_item;
    fcds_pkg::t_result w_res, w_out;
    logic              w_full, w_go;

    // the held item is applied only once the output stage has a free entry
    assign w_go = r_iv && !w_full;
    assign o_stall = r_iv && w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_iv <= 1'b0;
        else if (!o_stall) r_iv <= i_valid;
        if (!o_stall) r_item <= {i_command, i_chan, i_reg_index, i_data_byte, i_occasion};
    end

    fcds_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(w_go), .i_item(r_item), .o_res(w_res)
    );

    fcds_outreg u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_go), .i_res(w_res),
        .o_full(w_full), .o_valid(o_valid), .i_stall(i_stall), .o_res(w_out)
    );

    assign o_read_byte    = w_out.read_byte;
    assign o_xfer_valid   = w_out.xfer_valid;
    assign o_xfer_channel = w_out.xfer_channel;
    assign o_src_address  = w_out.src_address;
    assign o_dst_address  = w_out.dst_address;
    assign o_word_size    = w_out.word_size;
    assign o_do_read      = w_out.do_read;
    assign o_sequential   = w_out.sequential;
    assign o_irq_request  = w_out.irq_request;
    assign o_block_done   = w_out.block_done;
    assign o_busy_res     = w_out.busy_res;
endmodule

>>> src/fcds_checker.sv
// Port-level checker for the DMA sequencer, bound to the top level
`include "assert_macros.svh"
module fcds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_xfer_valid,
    input logic        o_block_done,
    input logic        o_irq_request,
    input logic [31:0] o_src_address,
    input logic [7:0]  o_read_byte
);
    `CHK_IMPL(a_irq_needs_done, i_clk, i_rst_n, o_valid && o_irq_request, o_block_done)
    `CHK_IMPL(a_done_needs_xfer, i_clk, i_rst_n, o_valid && o_block_done, o_xfer_valid)
    `CHK_IMPL(a_xfer_no_read, i_clk, i_rst_n, o_valid && o_xfer_valid, o_read_byte == 8'd0)
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_src_address))
endmodule

bind four_channel_dma_sequencer fcds_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_xfer_valid(o_xfer_valid), .o_block_done(o_block_done),
    .o_irq_request(o_irq_request), .o_src_address(o_src_address),
    .o_read_byte(o_read_byte)
);
